[design/rsz_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsz_pkg
// Shared constants, register codes and types of the resize and normalise
// block.
// ----------------------------------------------------------------------------
package rsz_pkg;

  localparam int OUT_SIZE_DEF   = 224;
  localparam int MAX_SOURCE_DEF = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MEAN_RED      = 3'd2;
  localparam logic [2:0] REG_MEAN_GREEN    = 3'd3;
  localparam logic [2:0] REG_MEAN_BLUE     = 3'd4;
  localparam logic [2:0] REG_INV_STD_RED   = 3'd5;
  localparam logic [2:0] REG_INV_STD_GREEN = 3'd6;
  localparam logic [2:0] REG_INV_STD_BLUE  = 3'd7;

  localparam logic [12:0] SOURCE_WIDTH_RST  = 13'd256;
  localparam logic [12:0] SOURCE_HEIGHT_RST = 13'd256;
  localparam logic [15:0] MEAN_RED_RST      = 16'd31429;
  localparam logic [15:0] MEAN_GREEN_RST    = 16'd29887;
  localparam logic [15:0] MEAN_BLUE_RST     = 16'd26648;
  localparam logic [15:0] INV_STD_RED_RST   = 16'd957;
  localparam logic [15:0] INV_STD_GREEN_RST = 16'd984;
  localparam logic [15:0] INV_STD_BLUE_RST  = 16'd932;

  typedef struct packed {
    logic [12:0] source_width;
    logic [12:0] source_height;
    logic [15:0] mean_red;
    logic [15:0] mean_green;
    logic [15:0] mean_blue;
    logic [15:0] inv_std_red;
    logic [15:0] inv_std_green;
    logic [15:0] inv_std_blue;
  } rsz_cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } rsz_item_t;

endpackage
`default_nettype wire

[design/nearest_resize_channel_normalize.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_resize_channel_normalize
// Nearest-neighbour downscaler with per-channel mean/deviation normalisation.
// A chosen source pixel enters the queue, then the subtract, multiply and
// round/saturate registers; throughput one source pixel per cycle while the
// queue is not full, set by the position compare in the front stage and the
// normalise pipe. Reset: position counters cleared, registers take their
// defaults, queue and pipeline empty.
// ----------------------------------------------------------------------------
module nearest_resize_channel_normalize #(
  parameter int OUT_SIZE   = rsz_pkg::OUT_SIZE_DEF,
  parameter int MAX_SOURCE = rsz_pkg::MAX_SOURCE_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                src_valid,
  output logic               src_stall,
  input  wire  [7:0]         red,
  input  wire  [7:0]         green,
  input  wire  [7:0]         blue,
  input  wire                frame_start,
  output logic               dst_valid,
  input  wire                dst_stall,
  output logic signed [15:0] norm_red,
  output logic signed [15:0] norm_green,
  output logic signed [15:0] norm_blue,
  output logic [7:0]         out_col,
  output logic [7:0]         out_row,
  output logic               frame_last
);
  import rsz_pkg::*;

  rsz_cfg_t   cfg;
  rsz_item_t  push_item, head_item;
  logic       push, pop, queue_full, queue_empty;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= SOURCE_WIDTH_RST;
      cfg.source_height <= SOURCE_HEIGHT_RST;
      cfg.mean_red      <= MEAN_RED_RST;
      cfg.mean_green    <= MEAN_GREEN_RST;
      cfg.mean_blue     <= MEAN_BLUE_RST;
      cfg.inv_std_red   <= INV_STD_RED_RST;
      cfg.inv_std_green <= INV_STD_GREEN_RST;
      cfg.inv_std_blue  <= INV_STD_BLUE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_SOURCE_WIDTH:  cfg.source_width  <= pwdata[12:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= pwdata[12:0];
        REG_MEAN_RED:      cfg.mean_red      <= pwdata[15:0];
        REG_MEAN_GREEN:    cfg.mean_green    <= pwdata[15:0];
        REG_MEAN_BLUE:     cfg.mean_blue     <= pwdata[15:0];
        REG_INV_STD_RED:   cfg.inv_std_red   <= pwdata[15:0];
        REG_INV_STD_GREEN: cfg.inv_std_green <= pwdata[15:0];
        REG_INV_STD_BLUE:  cfg.inv_std_blue  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SOURCE_WIDTH:  prdata = 32'(cfg.source_width);
      REG_SOURCE_HEIGHT: prdata = 32'(cfg.source_height);
      REG_MEAN_RED:      prdata = 32'(cfg.mean_red);
      REG_MEAN_GREEN:    prdata = 32'(cfg.mean_green);
      REG_MEAN_BLUE:     prdata = 32'(cfg.mean_blue);
      REG_INV_STD_RED:   prdata = 32'(cfg.inv_std_red);
      REG_INV_STD_GREEN: prdata = 32'(cfg.inv_std_green);
      REG_INV_STD_BLUE:  prdata = 32'(cfg.inv_std_blue);
      default:           prdata = '0;
    endcase
  end

  rsz_front #(
    .OUT_SIZE   (OUT_SIZE),
    .MAX_SOURCE (MAX_SOURCE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  rsz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  rsz_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_item  (head_item),
    .empty      (queue_empty),
    .pop        (pop),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .norm_red   (norm_red),
    .norm_green (norm_green),
    .norm_blue  (norm_blue),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

endmodule
`default_nettype wire

[design/rsz_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsz_front
// Source position tracking and nearest-neighbour pixel selection; chosen
// pixels are pushed into the queue.
// ----------------------------------------------------------------------------
module rsz_front #(
  parameter int OUT_SIZE   = rsz_pkg::OUT_SIZE_DEF,
  parameter int MAX_SOURCE = rsz_pkg::MAX_SOURCE_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  rsz_pkg::rsz_cfg_t   cfg,
  input  wire                 src_valid,
  output logic                src_stall,
  input  wire  [7:0]          red,
  input  wire  [7:0]          green,
  input  wire  [7:0]          blue,
  input  wire                 frame_start,
  input  wire                 queue_full,
  output logic                push,
  output rsz_pkg::rsz_item_t  push_item
);
  import rsz_pkg::*;

  localparam int OC_W  = $clog2(OUT_SIZE + 1);
  localparam int SC_W  = $clog2(MAX_SOURCE);
  localparam int SZ_W  = $clog2(MAX_SOURCE + 1);
  localparam int NUM_W = $clog2(OUT_SIZE * MAX_SOURCE + 1);

  logic [SC_W-1:0]  src_col, src_row, src_col_next, src_row_next;
  logic [OC_W-1:0]  out_col_count, out_row_count, out_col_count_next, out_row_count_next;
  logic [NUM_W-1:0] col_numerator, row_numerator, col_numerator_next, row_numerator_next;
  logic [NUM_W-1:0] col_scaled, row_scaled, col_scaled_next, row_scaled_next;

  logic [SC_W-1:0]  cur_scol, cur_srow;
  logic [OC_W-1:0]  cur_ocol, cur_orow;
  logic [NUM_W-1:0] cur_cnum, cur_rnum, cur_cscl, cur_rscl;
  logic [SZ_W-1:0]  w, h;
  logic             col_hit, row_hit, accept;

  assign src_stall = queue_full;
  assign accept    = src_valid && !queue_full;

  always_comb begin
    if (32'(cfg.source_width) < 32'(OUT_SIZE)) begin
      w = SZ_W'(OUT_SIZE);
    end else if (32'(cfg.source_width) > 32'(MAX_SOURCE)) begin
      w = SZ_W'(MAX_SOURCE);
    end else begin
      w = SZ_W'(cfg.source_width);
    end
    if (32'(cfg.source_height) < 32'(OUT_SIZE)) begin
      h = SZ_W'(OUT_SIZE);
    end else if (32'(cfg.source_height) > 32'(MAX_SOURCE)) begin
      h = SZ_W'(MAX_SOURCE);
    end else begin
      h = SZ_W'(cfg.source_height);
    end
  end

  always_comb begin
    cur_scol = frame_start ? '0 : src_col;
    cur_srow = frame_start ? '0 : src_row;
    cur_ocol = frame_start ? '0 : out_col_count;
    cur_orow = frame_start ? '0 : out_row_count;
    cur_cnum = frame_start ? '0 : col_numerator;
    cur_rnum = frame_start ? '0 : row_numerator;
    cur_cscl = frame_start ? '0 : col_scaled;
    cur_rscl = frame_start ? '0 : row_scaled;

    col_hit = (cur_ocol < OC_W'(OUT_SIZE)) && (cur_cnum < cur_cscl + NUM_W'(OUT_SIZE));
    row_hit = (cur_orow < OC_W'(OUT_SIZE)) && (cur_rnum < cur_rscl + NUM_W'(OUT_SIZE));

    push            = accept && col_hit && row_hit;
    push_item.red   = red;
    push_item.green = green;
    push_item.blue  = blue;
    push_item.col   = 8'(cur_ocol);
    push_item.row   = 8'(cur_orow);
    push_item.last  = (cur_ocol == OC_W'(OUT_SIZE - 1)) && (cur_orow == OC_W'(OUT_SIZE - 1));

    out_col_count_next = col_hit ? cur_ocol + OC_W'(1) : cur_ocol;
    col_numerator_next = col_hit ? cur_cnum + NUM_W'(w) : cur_cnum;
    src_col_next       = cur_scol;
    col_scaled_next    = cur_cscl;
    src_row_next       = cur_srow;
    out_row_count_next = cur_orow;
    row_numerator_next = cur_rnum;
    row_scaled_next    = cur_rscl;

    if (SZ_W'(cur_scol) >= w - SZ_W'(1)) begin
      src_col_next       = '0;
      out_col_count_next = '0;
      col_numerator_next = '0;
      col_scaled_next    = '0;
      if (SZ_W'(cur_srow) >= h - SZ_W'(1)) begin
        src_row_next       = '0;
        out_row_count_next = '0;
        row_numerator_next = '0;
        row_scaled_next    = '0;
      end else begin
        if (row_hit) begin
          out_row_count_next = cur_orow + OC_W'(1);
          row_numerator_next = cur_rnum + NUM_W'(h);
        end
        src_row_next    = cur_srow + SC_W'(1);
        row_scaled_next = cur_rscl + NUM_W'(OUT_SIZE);
      end
    end else begin
      src_col_next    = cur_scol + SC_W'(1);
      col_scaled_next = cur_cscl + NUM_W'(OUT_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      out_col_count <= '0;
      out_row_count <= '0;
      col_numerator <= '0;
      row_numerator <= '0;
      col_scaled    <= '0;
      row_scaled    <= '0;
    end else if (accept) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      out_col_count <= out_col_count_next;
      out_row_count <= out_row_count_next;
      col_numerator <= col_numerator_next;
      row_numerator <= row_numerator_next;
      col_scaled    <= col_scaled_next;
      row_scaled    <= row_scaled_next;
    end
  end

endmodule
`default_nettype wire

[design/rsz_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsz_queue
// Short first-in first-out queue of chosen pixels between selection and
// normalisation.
// ----------------------------------------------------------------------------
module rsz_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  rsz_pkg::rsz_item_t  push_item,
  input  wire                 pop,
  output rsz_pkg::rsz_item_t  head_item,
  output logic                full,
  output logic                empty
);
  import rsz_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rsz_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[design/rsz_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsz_back
// Per-channel normalisation pipeline: subtract mean, multiply by the
// reciprocal deviation, round and saturate into the output register.
// ----------------------------------------------------------------------------
module rsz_back (
  input  wire                 clk,
  input  wire                 rst,
  input  rsz_pkg::rsz_cfg_t   cfg,
  input  rsz_pkg::rsz_item_t  head_item,
  input  wire                 empty,
  output logic                pop,
  output logic                dst_valid,
  input  wire                 dst_stall,
  output logic signed [15:0]  norm_red,
  output logic signed [15:0]  norm_green,
  output logic signed [15:0]  norm_blue,
  output logic [7:0]          out_col,
  output logic [7:0]          out_row,
  output logic                frame_last
);
  import rsz_pkg::*;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } pos_t;

  logic               v1, v2, v3, advance;
  pos_t               pos1, pos2;
  logic signed [16:0] diff_r, diff_g, diff_b;
  logic signed [33:0] prod_r, prod_g, prod_b;

  function automatic logic signed [15:0] round_sat(input logic signed [33:0] p);
    logic signed [33:0] t;
    logic signed [21:0] q;
    t = p + 34'sd2048;
    q = 22'(t >>> 12);
    if (q > 22'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -22'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  assign advance = !v3 || !dst_stall;
  assign pop     = advance && !empty;
  assign dst_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      diff_r <= $signed({1'b0, head_item.red, 8'd0}) - $signed({1'b0, cfg.mean_red});
      diff_g <= $signed({1'b0, head_item.green, 8'd0}) - $signed({1'b0, cfg.mean_green});
      diff_b <= $signed({1'b0, head_item.blue, 8'd0}) - $signed({1'b0, cfg.mean_blue});
      pos1   <= '{col: head_item.col, row: head_item.row, last: head_item.last};

      prod_r <= 34'(diff_r * $signed({1'b0, cfg.inv_std_red}));
      prod_g <= 34'(diff_g * $signed({1'b0, cfg.inv_std_green}));
      prod_b <= 34'(diff_b * $signed({1'b0, cfg.inv_std_blue}));
      pos2   <= pos1;

      norm_red   <= round_sat(prod_r);
      norm_green <= round_sat(prod_g);
      norm_blue  <= round_sat(prod_b);
      out_col    <= pos2.col;
      out_row    <= pos2.row;
      frame_last <= pos2.last;
    end
  end

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for nearest_resize_channel_normalize
// Drives source pixels through the valid/stall channel and programs the
// registers over the APB-style port with readback. An in-bench model of the
// downscaler and the per-channel normaliser predicts every output pixel.
// The run has a short directed table, random phases with random register
// settings and idling, and one stretch across a row end without idling.
// ----------------------------------------------------------------------------
module testbench;
  import rsz_pkg::*;

  localparam int OUT           = OUT_SIZE_DEF;
  localparam int MAXSRC        = MAX_SOURCE_DEF;
  localparam int RANDOM_PIXELS = 160;
  localparam int FRAME_W       = 224;
  localparam int TAIL_PIXELS   = 240;
  localparam int DRAIN_CYCLES  = 8;
  localparam int ROW_COUNT     = 16;

  typedef struct packed {
    logic signed [15:0] nred;
    logic signed [15:0] ngreen;
    logic signed [15:0] nblue;
    logic [7:0]         col;
    logic [7:0]         row;
    logic               last;
  } norm_pix_t;

  typedef struct packed {
    logic [1:0] setting;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fs;
    logic       typed;
    norm_pix_t  want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               src_valid = 1'b0;
  logic               src_stall;
  logic [7:0]         red = '0;
  logic [7:0]         green = '0;
  logic [7:0]         blue = '0;
  logic               frame_start = 1'b0;
  logic               dst_valid;
  logic               dst_stall = 1'b0;
  logic signed [15:0] norm_red;
  logic signed [15:0] norm_green;
  logic signed [15:0] norm_blue;
  logic [7:0]         out_col;
  logic [7:0]         out_row;
  logic               frame_last;

  nearest_resize_channel_normalize dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .src_valid(src_valid), .src_stall(src_stall),
    .red(red), .green(green), .blue(blue), .frame_start(frame_start),
    .dst_valid(dst_valid), .dst_stall(dst_stall),
    .norm_red(norm_red), .norm_green(norm_green), .norm_blue(norm_blue),
    .out_col(out_col), .out_row(out_row), .frame_last(frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  rsz_cfg_t    cfg;
  logic [11:0] pos_col, pos_row;
  logic [7:0]  next_col, next_row;
  logic [19:0] col_target, row_target, col_reach, row_reach;

  norm_pix_t pending_pixels[$];
  int        mismatch_count = 0;
  int        pixels_sent = 0;
  int        outputs_seen = 0;
  int        frames_ended = 0;
  int        settings_applied = 0;
  bit        idle_on = 1'b0;
  int        stall_left = 0;

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH %s", msg);
  endfunction

  function automatic int unsigned clamp_size(input logic [12:0] s);
    if (s < OUT) return OUT;
    if (s > MAXSRC) return MAXSRC;
    return s;
  endfunction

  function automatic void clear_position();
    pos_col = '0;
    pos_row = '0;
    next_col = '0;
    next_row = '0;
    col_target = '0;
    row_target = '0;
    col_reach = '0;
    row_reach = '0;
  endfunction

  function automatic logic signed [15:0] norm_channel(input logic [7:0] v,
                                                      input logic [15:0] mean,
                                                      input logic [15:0] inv_std);
    longint prod, q;
    prod = (longint'(v) * 256 - longint'(mean)) * longint'(inv_std);
    q = (prod + 2048) >>> 12;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void resize_step(input logic [7:0] r, g, b, input logic fs,
                                      output bit hit, output norm_pix_t px);
    int unsigned w, h;
    bit col_hit, row_hit;
    if (fs) clear_position();
    w = clamp_size(cfg.source_width);
    h = clamp_size(cfg.source_height);
    col_hit = next_col < OUT && col_target < col_reach + OUT;
    row_hit = next_row < OUT && row_target < row_reach + OUT;
    hit = col_hit && row_hit;
    px.nred = norm_channel(r, cfg.mean_red, cfg.inv_std_red);
    px.ngreen = norm_channel(g, cfg.mean_green, cfg.inv_std_green);
    px.nblue = norm_channel(b, cfg.mean_blue, cfg.inv_std_blue);
    px.col = next_col;
    px.row = next_row;
    px.last = (next_col == OUT - 1) && (next_row == OUT - 1);
    if (col_hit) begin
      next_col++;
      col_target += w;
    end
    if (pos_col >= w - 1) begin
      pos_col = '0;
      next_col = '0;
      col_target = '0;
      col_reach = '0;
      if (pos_row >= h - 1) begin
        clear_position();
      end else begin
        if (row_hit) begin
          next_row++;
          row_target += h;
        end
        pos_row++;
        row_reach += OUT;
      end
    end else begin
      pos_col++;
      col_reach += OUT;
    end
  endfunction

  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 13'd224;
      1: return 13'($urandom_range(224, 264));
      2: return 13'd4096;
      3: return 13'($urandom_range(0, 223));
      4: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(224, 4096));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 2047));
      3: return 16'($urandom_range(16'h6000, 16'h8FFF));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic rsz_cfg_t random_setting();
    rsz_cfg_t s;
    s.source_width = pick_size();
    s.source_height = pick_size();
    s.mean_red = pick_word();
    s.mean_green = pick_word();
    s.mean_blue = pick_word();
    s.inv_std_red = pick_word();
    s.inv_std_green = pick_word();
    s.inv_std_blue = pick_word();
    return s;
  endfunction

  task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_SOURCE_WIDTH || idx == REG_SOURCE_HEIGHT) ? 32'h1FFF : 32'hFFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SOURCE_WIDTH:  cfg.source_width = value[12:0];
      REG_SOURCE_HEIGHT: cfg.source_height = value[12:0];
      REG_MEAN_RED:      cfg.mean_red = value[15:0];
      REG_MEAN_GREEN:    cfg.mean_green = value[15:0];
      REG_MEAN_BLUE:     cfg.mean_blue = value[15:0];
      REG_INV_STD_RED:   cfg.inv_std_red = value[15:0];
      REG_INV_STD_GREEN: cfg.inv_std_green = value[15:0];
      REG_INV_STD_BLUE:  cfg.inv_std_blue = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      note_mismatch($sformatf("readback reg %0d: expected %h got %h",
                              idx, value & mask, prdata & mask));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Enter at a falling edge; drain the pipe before touching any register.
  task automatic apply_setting(input rsz_cfg_t s);
    src_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    program_reg(REG_SOURCE_WIDTH, 32'(s.source_width));
    program_reg(REG_SOURCE_HEIGHT, 32'(s.source_height));
    program_reg(REG_MEAN_RED, 32'(s.mean_red));
    program_reg(REG_MEAN_GREEN, 32'(s.mean_green));
    program_reg(REG_MEAN_BLUE, 32'(s.mean_blue));
    program_reg(REG_INV_STD_RED, 32'(s.inv_std_red));
    program_reg(REG_INV_STD_GREEN, 32'(s.inv_std_green));
    program_reg(REG_INV_STD_BLUE, 32'(s.inv_std_blue));
    settings_applied++;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input logic fs,
                            input bit typed, input norm_pix_t want);
    bit hit;
    norm_pix_t px;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    src_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    frame_start <= fs;
    do @(posedge clk); while (src_stall);
    resize_step(r, g, b, fs, hit, px);
    if (hit) pending_pixels.push_back(typed ? want : px);
    pixels_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 11);
    if (idle_on && stall_left > 0) begin
      dst_stall <= 1'b1;
      stall_left--;
    end else begin
      dst_stall <= 1'b0;
      stall_left = 0;
    end
  end

  always @(posedge clk) begin : output_check
    norm_pix_t got, exp_px;
    if (!rst && dst_valid && !dst_stall) begin
      got.nred = norm_red;
      got.ngreen = norm_green;
      got.nblue = norm_blue;
      got.col = out_col;
      got.row = out_row;
      got.last = frame_last;
      outputs_seen++;
      if (frame_last) frames_ended++;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected output col %0d row %0d", out_col, out_row));
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got !== exp_px)
          note_mismatch($sformatf(
            "expected r %0d g %0d b %0d col %0d row %0d last %0b, got r %0d g %0d b %0d col %0d row %0d last %0b",
            exp_px.nred, exp_px.ngreen, exp_px.nblue, exp_px.col, exp_px.row, exp_px.last,
            got.nred, got.ngreen, got.nblue, got.col, got.row, got.last));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d outputs outstanding", pending_pixels.size());
    $display("** nearest_resize_channel_normalize: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t directed_rows [ROW_COUNT];
    rsz_cfg_t  settings [3];
    rsz_cfg_t  fresh;
    int        cur_setting, random_sent, len;
    bit        fs;

    settings[0] = '{SOURCE_WIDTH_RST, SOURCE_HEIGHT_RST, MEAN_RED_RST, MEAN_GREEN_RST,
                    MEAN_BLUE_RST, INV_STD_RED_RST, INV_STD_GREEN_RST, INV_STD_BLUE_RST};
    settings[1] = '{13'd224, 13'd224, 16'h0000, 16'hFFFF, 16'h8000,
                    16'hFFFF, 16'hFFFF, 16'h0000};
    settings[2] = '{13'h1FFF, 13'd0, 16'hFFFF, 16'h0000, 16'h8000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF};
    directed_rows = '{
      '{2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0},
      '{2'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '0},
      '{2'd0, 8'h80, 8'h7F, 8'h01, 1'b0, 1'b0, '0},
      '{2'd0, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0, '0},
      '{2'd0, 8'hAA, 8'h55, 8'hFF, 1'b0, 1'b0, '0},
      '{2'd1, 8'hFF, 8'h00, 8'h5A, 1'b1, 1'b1,
        '{16'sh7FFF, 16'sh8000, 16'sh0000, 8'd0, 8'd0, 1'b0}},
      '{2'd1, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1,
        '{16'sh0000, 16'sh8000, 16'sh0000, 8'd1, 8'd0, 1'b0}},
      '{2'd1, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1,
        '{16'sh7FFF, 16'sh8000, 16'sh0000, 8'd2, 8'd0, 1'b0}},
      '{2'd1, 8'h00, 8'h00, 8'h81, 1'b1, 1'b1,
        '{16'sh0000, 16'sh8000, 16'sh0000, 8'd0, 8'd0, 1'b0}},
      '{2'd1, 8'hC3, 8'hFF, 8'h3C, 1'b0, 1'b0, '0},
      '{2'd2, 8'h00, 8'hFF, 8'h80, 1'b1, 1'b1,
        '{16'sh8000, 16'sh7FFF, 16'sh0000, 8'd0, 8'd0, 1'b0}},
      '{2'd2, 8'hFF, 8'h00, 8'h80, 1'b0, 1'b0, '0},
      '{2'd2, 8'h5A, 8'hA5, 8'h0F, 1'b0, 1'b0, '0},
      '{2'd2, 8'h01, 8'hFE, 8'hF0, 1'b0, 1'b0, '0},
      '{2'd2, 8'h7F, 8'h80, 8'hC3, 1'b0, 1'b0, '0},
      '{2'd0, 8'h3C, 8'hC3, 8'h99, 1'b1, 1'b0, '0}
    };

    cfg = settings[0];
    clear_position();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    cur_setting = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != cur_setting) begin
        cur_setting = directed_rows[i].setting;
        apply_setting(settings[cur_setting]);
      end
      send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                 directed_rows[i].fs, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases: no frame start on entry leaves the size change mid-frame
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      apply_setting(random_setting());
      idle_on = $urandom_range(0, 3) != 0;
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        fs = (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 63) == 0;
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), fs, 1'b0, '0);
      end
      random_sent += len;
    end

    // Narrowest frame, run back to back across the first row end
    fresh = random_setting();
    fresh.source_width = 13'(FRAME_W);
    fresh.source_height = 13'(FRAME_W);
    apply_setting(fresh);
    idle_on = 1'b0;
    for (int i = 0; i < TAIL_PIXELS; i++)
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), i == 0, 1'b0, '0);
    src_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d source pixels under %0d register settings plus reset values;",
             pixels_sent, settings_applied);
    $display("checked %0d output pixels, %0d frame ends, %0d mismatches.",
             outputs_seen, frames_ended, mismatch_count);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("** nearest_resize_channel_normalize: PASSED **");
    end else begin
      $display("** nearest_resize_channel_normalize: FAILED **");
    end
    $finish;
  end

endmodule
